[design/alids_pkg.sv]
// Shared types, sizes and codes for the array list insert/delete/search unit.
`default_nettype none
package alids_pkg;

  // Store size and derived widths
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W + 1 : 6;

  typedef logic signed [31:0] data_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [CMP_W-1:0]   cmp_t;
  typedef logic [4:0]         pos_t;
  typedef logic [DEPTH-1:0]   vec_t;

  // Operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_SEARCH = 2'd2;
  localparam logic [1:0] FUNC_COUNT  = 2'd3;

  // Result status codes
  localparam logic [2:0] STAT_DONE     = 3'd0;
  localparam logic [2:0] STAT_BADPOS   = 3'd1;
  localparam logic [2:0] STAT_FULL     = 3'd2;
  localparam logic [2:0] STAT_FOUND    = 3'd3;
  localparam logic [2:0] STAT_NOTFOUND = 3'd4;
  localparam logic [2:0] STAT_COUNT    = 3'd5;

  typedef struct packed {
    logic [1:0] func;
    pos_t       position;
    data_t      value;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    pos_t       found_position;
    pos_t       element_count;
    logic       last;
  } rsp_t;

  // Per-cell update command
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_LEFT,
    CELL_RIGHT
  } cell_op_t;

  // Match scanner status toward the controller
  typedef struct packed {
    logic empty;
    idx_t idx;
    logic last;
  } scan_t;

endpackage
`default_nettype wire

[design/array_list_insert_delete_search_unit.sv]
// Top level of the array list unit: cell chain, match scanner and control.
// Usage:
//   req carries one operation (insert, delete, search, count query) and is
//   transferred when req_valid and req_ready are high at a rising edge.
//   rsp carries one result, transferred when rsp_valid and rsp_ready are high.
//   The result register holds a finished result while the receiver stalls;
//   req_ready stays low until that register is free or being emptied.
// Latency and throughput:
//   Insert, delete and count query give their single result in the cycle after
//   the transfer; with rsp_ready high a new item is taken every cycle, since
//   each cell loads its neighbor's entry directly into its own register.
//   A search compares all cells in the transfer cycle, then emits one found
//   result per cycle from the match scanner while the receiver does not stall,
//   lowest position first, or one not-found result; the next item is taken
//   after its last result is loaded.
// Reset:
//   rst (synchronous) empties the store (count zero) and clears rsp_valid.
//   Entry contents are not cleared; only occupied entries are ever compared.
`default_nettype none
module array_list_insert_delete_search_unit (
  input  wire                clk,
  input  wire                rst,
  input  wire                req_valid,
  output logic               req_ready,
  input  alids_pkg::req_t    req,
  output logic               rsp_valid,
  input  wire                rsp_ready,
  output alids_pkg::rsp_t    rsp
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                     state;
  logic                     state_next;
  alids_pkg::count_t        count;
  alids_pkg::count_t        count_next;
  logic                     rsp_valid_next;
  alids_pkg::rsp_t          rsp_next;
  logic                     rsp_load;
  logic                     slot_free;
  logic                     take;
  logic                     ins_ok;
  logic                     del_ok;
  logic                     scan_load;
  logic                     scan_advance;
  alids_pkg::cmp_t          pos_c;
  alids_pkg::cmp_t          cnt_c;
  alids_pkg::count_t        hit_pos;
  alids_pkg::scan_t         scan;
  alids_pkg::vec_t          match_vec;
  alids_pkg::data_t         cell_data [alids_pkg::DEPTH];
  alids_pkg::cell_op_t      cell_op   [alids_pkg::DEPTH];

  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && slot_free;
  assign take      = req_valid && req_ready;

  // Check positions against the current count
  assign pos_c  = alids_pkg::cmp_t'(req.position);
  assign cnt_c  = alids_pkg::cmp_t'(count);
  assign ins_ok = (pos_c != '0) && (pos_c <= cnt_c + alids_pkg::cmp_t'(1))
                  && (cnt_c < alids_pkg::cmp_t'(alids_pkg::DEPTH));
  assign del_ok = (pos_c != '0) && (pos_c <= cnt_c);

  // Cell chain: per-cell shift commands and storage
  for (genvar i = 0; i < alids_pkg::DEPTH; i++) begin : g_cell
    alids_pkg::data_t left_d;
    alids_pkg::data_t right_d;
    logic             occ;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == alids_pkg::DEPTH - 1) begin : g_final
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    assign occ = alids_pkg::cmp_t'(i) < cnt_c;

    always_comb begin
      cell_op[i] = alids_pkg::CELL_HOLD;
      if (take && req.func == alids_pkg::FUNC_INSERT && ins_ok) begin
        if (alids_pkg::cmp_t'(i + 1) == pos_c) begin
          cell_op[i] = alids_pkg::CELL_LOAD;
        end else if (alids_pkg::cmp_t'(i + 1) > pos_c) begin
          cell_op[i] = alids_pkg::CELL_LEFT;
        end
      end else if (take && req.func == alids_pkg::FUNC_DELETE && del_ok) begin
        if (alids_pkg::cmp_t'(i + 1) >= pos_c) begin
          cell_op[i] = alids_pkg::CELL_RIGHT;
        end
      end
    end

    alids_cell u_cell (
      .clk      (clk),
      .op       (cell_op[i]),
      .value    (req.value),
      .left     (left_d),
      .right    (right_d),
      .occupied (occ),
      .data     (cell_data[i]),
      .match    (match_vec[i])
    );
  end

  // Match scanner
  assign scan_load    = take && (req.func == alids_pkg::FUNC_SEARCH);
  assign scan_advance = (state == S_SCAN) && slot_free && !scan.empty;

  alids_scan u_scan (
    .clk      (clk),
    .load     (scan_load),
    .load_vec (match_vec),
    .advance  (scan_advance),
    .scan     (scan)
  );

  assign hit_pos = alids_pkg::count_t'(scan.idx) + alids_pkg::count_t'(1);

  // Control: count update, result selection, state
  always_comb begin
    state_next = state;
    count_next = count;
    rsp_load   = 1'b0;
    rsp_next   = rsp;
    if (take) begin
      rsp_next.found_position = '0;
      rsp_next.last           = 1'b1;
      rsp_next.element_count  = alids_pkg::pos_t'(count);
      unique case (req.func)
        alids_pkg::FUNC_INSERT: begin
          rsp_load = 1'b1;
          if (ins_ok) begin
            count_next             = count + alids_pkg::count_t'(1);
            rsp_next.status        = alids_pkg::STAT_DONE;
            rsp_next.element_count = alids_pkg::pos_t'(count + alids_pkg::count_t'(1));
          end else if (pos_c == '0 || pos_c > cnt_c + alids_pkg::cmp_t'(1)) begin
            rsp_next.status = alids_pkg::STAT_BADPOS;
          end else begin
            rsp_next.status = alids_pkg::STAT_FULL;
          end
        end
        alids_pkg::FUNC_DELETE: begin
          rsp_load = 1'b1;
          if (del_ok) begin
            count_next             = count - alids_pkg::count_t'(1);
            rsp_next.status        = alids_pkg::STAT_DONE;
            rsp_next.element_count = alids_pkg::pos_t'(count - alids_pkg::count_t'(1));
          end else begin
            rsp_next.status = alids_pkg::STAT_BADPOS;
          end
        end
        alids_pkg::FUNC_SEARCH: begin
          state_next = S_SCAN;
        end
        default: begin
          rsp_load        = 1'b1;
          rsp_next.status = alids_pkg::STAT_COUNT;
        end
      endcase
    end else if (state == S_SCAN && slot_free) begin
      rsp_load               = 1'b1;
      rsp_next.element_count = alids_pkg::pos_t'(count);
      if (scan.empty) begin
        rsp_next.status         = alids_pkg::STAT_NOTFOUND;
        rsp_next.found_position = '0;
        rsp_next.last           = 1'b1;
        state_next              = S_IDLE;
      end else begin
        rsp_next.status         = alids_pkg::STAT_FOUND;
        rsp_next.found_position = alids_pkg::pos_t'(hit_pos);
        rsp_next.last           = scan.last;
        if (scan.last) begin
          state_next = S_IDLE;
        end
      end
    end
  end

  // Result register valid: set on load, drop on transfer
  always_comb begin
    rsp_valid_next = rsp_valid;
    if (rsp_load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Hold result payload
  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

endmodule
`default_nettype wire

[design/alids_cell.sv]
// One storage cell of the entry chain: holds an entry, shifts and compares.
`default_nettype none
module alids_cell (
  input  wire                    clk,
  input  alids_pkg::cell_op_t    op,
  input  alids_pkg::data_t       value,
  input  alids_pkg::data_t       left,
  input  alids_pkg::data_t       right,
  input  wire                    occupied,
  output alids_pkg::data_t       data,
  output logic                   match
);

  alids_pkg::data_t entry;

  // Load, shift from a neighbor, or hold
  always_ff @(posedge clk) begin
    unique case (op)
      alids_pkg::CELL_LOAD:  entry <= value;
      alids_pkg::CELL_LEFT:  entry <= left;
      alids_pkg::CELL_RIGHT: entry <= right;
      default:               entry <= entry;
    endcase
  end

  assign data  = entry;
  assign match = occupied && (entry == value);

endmodule
`default_nettype wire

[design/alids_scan.sv]
// Match vector register that hands out matching positions lowest first.
`default_nettype none
module alids_scan (
  input  wire                 clk,
  input  wire                 load,
  input  alids_pkg::vec_t     load_vec,
  input  wire                 advance,
  output alids_pkg::scan_t    scan
);

  alids_pkg::vec_t mask;
  alids_pkg::vec_t rest;
  alids_pkg::idx_t low_idx;

  // Find the lowest pending match
  always_comb begin
    low_idx = '0;
    for (int i = alids_pkg::DEPTH - 1; i >= 0; i--) begin
      if (mask[i]) begin
        low_idx = alids_pkg::idx_t'(i);
      end
    end
  end

  assign rest = mask & (mask - alids_pkg::vec_t'(1));

  // Capture a new vector or drop the match just reported
  always_ff @(posedge clk) begin
    if (load) begin
      mask <= load_vec;
    end else if (advance) begin
      mask <= rest;
    end
  end

  assign scan.empty = (mask == '0);
  assign scan.idx   = low_idx;
  assign scan.last  = (rest == '0);

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the array list insert/delete/search unit.
`default_nettype none
module tb_top;

  localparam int RESULT_CAP  = 16;
  localparam int RAND_ITEMS  = 240;
  localparam int LONG_HOLD   = 80;
  localparam int TAIL_CYCLES = 20;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [1:0]         func;
    alids_pkg::pos_t    position;
    alids_pkg::data_t   value;
    int                 rep;
    bit                 checked;
    alids_pkg::rsp_t    want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  alids_pkg::req_t req;
  logic rsp_valid;
  logic rsp_ready;
  alids_pkg::rsp_t rsp;

  // Shadow copy of the list and the queue of results still owed by the block
  alids_pkg::data_t list_mem [alids_pkg::DEPTH];
  int               list_len;
  alids_pkg::rsp_t  op_rsp [$];
  alids_pkg::rsp_t  rsp_expected [$];
  dir_row_t         dir_rows [$];

  int err_count;
  int stall_cycles;
  bit idle_on;
  bit long_hold_req;
  bit grow;

  array_list_insert_delete_search_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    err_count++;
  endtask

  // Apply one operation to the shadow list and collect the results it owes
  function automatic void apply_list_op(input alids_pkg::req_t r);
    int              p;
    int              hits;
    int              i;
    alids_pkg::rsp_t o;
    p = r.position;
    hits = 0;
    op_rsp.delete();
    o = '0;
    o.last = 1'b1;
    case (r.func)
      alids_pkg::FUNC_INSERT: begin
        if (p == 0 || p > list_len + 1) begin
          o.status = alids_pkg::STAT_BADPOS;
        end else if (list_len >= alids_pkg::DEPTH) begin
          o.status = alids_pkg::STAT_FULL;
        end else begin
          for (i = list_len; i > p - 1; i--) list_mem[i] = list_mem[i-1];
          list_mem[p-1] = r.value;
          list_len++;
          o.status = alids_pkg::STAT_DONE;
        end
        o.element_count = alids_pkg::pos_t'(list_len);
        op_rsp.push_back(o);
      end
      alids_pkg::FUNC_DELETE: begin
        if (p == 0 || p > list_len) begin
          o.status = alids_pkg::STAT_BADPOS;
        end else begin
          for (i = p - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
          o.status = alids_pkg::STAT_DONE;
        end
        o.element_count = alids_pkg::pos_t'(list_len);
        op_rsp.push_back(o);
      end
      alids_pkg::FUNC_SEARCH: begin
        o.element_count = alids_pkg::pos_t'(list_len);
        for (i = 0; i < list_len; i++) begin
          if (list_mem[i] == r.value && hits < RESULT_CAP) begin
            o.status = alids_pkg::STAT_FOUND;
            o.found_position = alids_pkg::pos_t'(i + 1);
            o.last = 1'b0;
            op_rsp.push_back(o);
            hits++;
          end
        end
        if (hits == 0) begin
          o.status = alids_pkg::STAT_NOTFOUND;
          o.found_position = '0;
          o.last = 1'b1;
          op_rsp.push_back(o);
        end else begin
          o = op_rsp.pop_back();
          o.last = 1'b1;
          op_rsp.push_back(o);
        end
      end
      default: begin
        o.status = alids_pkg::STAT_COUNT;
        o.element_count = alids_pkg::pos_t'(list_len);
        op_rsp.push_back(o);
      end
    endcase
  endfunction

  // Pick a value: mostly a small pool so searches hit duplicates
  function automatic alids_pkg::data_t pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return alids_pkg::data_t'($signed($urandom_range(0, 3)) - 1);
    if (roll < 65 && list_len > 0) return list_mem[$urandom_range(0, list_len - 1)];
    if (roll < 80) begin
      case ($urandom_range(0, 3))
        0: return alids_pkg::data_t'(32'h8000_0000);
        1: return alids_pkg::data_t'(32'h7FFF_FFFF);
        2: return alids_pkg::data_t'(32'hFFFF_FFFF);
        default: return '0;
      endcase
    end
    return alids_pkg::data_t'($urandom);
  endfunction

  // Build a random operation that wanders the list between empty and full
  function automatic alids_pkg::req_t make_random_req();
    alids_pkg::req_t r;
    int              roll;
    if (list_len >= alids_pkg::DEPTH) grow = 1'b0;
    if (list_len == 0) grow = 1'b1;
    if ($urandom_range(0, 49) == 0) grow = !grow;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      r.func = 2'($urandom);
      r.position = alids_pkg::pos_t'($urandom_range(0, 31));
      r.value = alids_pkg::data_t'($urandom);
      return r;
    end
    roll = $urandom_range(0, 99);
    if (roll < 10) r.func = alids_pkg::FUNC_COUNT;
    else if (roll < 32) r.func = alids_pkg::FUNC_SEARCH;
    else if ((roll < 76) == grow) r.func = alids_pkg::FUNC_INSERT;
    else r.func = alids_pkg::FUNC_DELETE;
    r.value = pick_value();
    r.position = alids_pkg::pos_t'($urandom_range(0, 31));
    if ($urandom_range(0, 9) != 0) begin
      if (r.func == alids_pkg::FUNC_INSERT)
        r.position = alids_pkg::pos_t'($urandom_range(1, list_len + 1));
      if (r.func == alids_pkg::FUNC_DELETE && list_len > 0)
        r.position = alids_pkg::pos_t'($urandom_range(1, list_len));
    end
    return r;
  endfunction

  task automatic add_row(input logic [1:0] func, input int position,
                         input alids_pkg::data_t value, input int rep, input bit checked,
                         input logic [2:0] status, input int count);
    dir_row_t d;
    d.func = func;
    d.position = alids_pkg::pos_t'(position);
    d.value = value;
    d.rep = rep;
    d.checked = checked;
    d.want = '{status: status, found_position: '0,
               element_count: alids_pkg::pos_t'(count), last: 1'b1};
    dir_rows.push_back(d);
  endtask

  // Offer one item and hold it until the transfer, then record what it owes
  task automatic drive_item(input alids_pkg::req_t r, input bit checked,
                            input alids_pkg::rsp_t want);
    int k;
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    apply_list_op(r);
    if (checked) begin
      rsp_expected.push_back(want);
    end else begin
      for (k = 0; k < op_rsp.size(); k++) rsp_expected.push_back(op_rsp[k]);
    end
    @(negedge clk);
  endtask

  task automatic maybe_pause();
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  // Hold off the sender until every owed result has come back
  task automatic wait_drained();
    if (rsp_expected.size() != 0) begin
      req_valid <= 1'b0;
      while (rsp_expected.size() != 0) @(negedge clk);
    end
  endtask

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 6);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    alids_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (rsp_expected.size() == 0) begin
        report("unexpected result, status", rsp.status, -1);
      end else begin
        want = rsp_expected.pop_front();
        if (rsp.status !== want.status) report("status", rsp.status, want.status);
        if (rsp.found_position !== want.found_position)
          report("found_position", rsp.found_position, want.found_position);
        if (rsp.element_count !== want.element_count)
          report("element_count", rsp.element_count, want.element_count);
        if (rsp.last !== want.last) report("last", rsp.last, want.last);
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || rst) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    alids_pkg::req_t r;
    alids_pkg::rsp_t none;
    int              i;
    int              n;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    none = '0;
    err_count = 0;
    stall_cycles = 0;
    idle_on = 1'b1;
    long_hold_req = 1'b0;
    grow = 1'b1;
    list_len = 0;
    for (i = 0; i < alids_pkg::DEPTH; i++) list_mem[i] = '0;

    // Directed rows: empty store, extremes, bad positions, full store, wide search
    add_row(alids_pkg::FUNC_COUNT,   0, '0, 1, 1, alids_pkg::STAT_COUNT, 0);
    add_row(alids_pkg::FUNC_DELETE,  1, '0, 1, 1, alids_pkg::STAT_BADPOS, 0);
    add_row(alids_pkg::FUNC_SEARCH,  0, '0, 1, 1, alids_pkg::STAT_NOTFOUND, 0);
    add_row(alids_pkg::FUNC_INSERT,  0, 1, 1, 1, alids_pkg::STAT_BADPOS, 0);
    add_row(alids_pkg::FUNC_INSERT,  2, 1, 1, 1, alids_pkg::STAT_BADPOS, 0);
    add_row(alids_pkg::FUNC_INSERT,  1, alids_pkg::data_t'(32'h7FFF_FFFF), 1, 1,
            alids_pkg::STAT_DONE, 1);
    add_row(alids_pkg::FUNC_INSERT,  1, alids_pkg::data_t'(32'h8000_0000), 1, 1,
            alids_pkg::STAT_DONE, 2);
    add_row(alids_pkg::FUNC_INSERT,  3, '0, 1, 1, alids_pkg::STAT_DONE, 3);
    add_row(alids_pkg::FUNC_INSERT, 31, 1, 1, 1, alids_pkg::STAT_BADPOS, 3);
    add_row(alids_pkg::FUNC_INSERT,  2, alids_pkg::data_t'(-1), 1, 0,
            alids_pkg::STAT_DONE, 0);
    add_row(alids_pkg::FUNC_SEARCH,  0, alids_pkg::data_t'(32'h8000_0000), 1, 0,
            alids_pkg::STAT_DONE, 0);
    add_row(alids_pkg::FUNC_SEARCH, 31, alids_pkg::data_t'(32'h7FFF_FFFF), 1, 0,
            alids_pkg::STAT_DONE, 0);
    add_row(alids_pkg::FUNC_DELETE, 31, '0, 1, 1, alids_pkg::STAT_BADPOS, 4);
    add_row(alids_pkg::FUNC_DELETE,  0, '0, 1, 1, alids_pkg::STAT_BADPOS, 4);
    add_row(alids_pkg::FUNC_DELETE,  4, '0, 1, 0, alids_pkg::STAT_DONE, 0);
    add_row(alids_pkg::FUNC_DELETE,  1, '0, 1, 0, alids_pkg::STAT_DONE, 0);
    add_row(alids_pkg::FUNC_INSERT,  1, 5, 14, 0, alids_pkg::STAT_DONE, 0);
    add_row(alids_pkg::FUNC_SEARCH,  0, 5, 1, 0, alids_pkg::STAT_DONE, 0);
    add_row(alids_pkg::FUNC_INSERT,  1, 9, 1, 1, alids_pkg::STAT_FULL, 16);
    add_row(alids_pkg::FUNC_INSERT, 17, 9, 1, 1, alids_pkg::STAT_FULL, 16);
    add_row(alids_pkg::FUNC_INSERT, 18, 9, 1, 1, alids_pkg::STAT_BADPOS, 16);
    add_row(alids_pkg::FUNC_INSERT,  0, 9, 1, 1, alids_pkg::STAT_BADPOS, 16);
    add_row(alids_pkg::FUNC_COUNT,   7, '0, 1, 1, alids_pkg::STAT_COUNT, 16);
    add_row(alids_pkg::FUNC_DELETE, 16, '0, 1, 0, alids_pkg::STAT_DONE, 0);
    add_row(alids_pkg::FUNC_DELETE, 15, '0, 1, 0, alids_pkg::STAT_DONE, 0);
    add_row(alids_pkg::FUNC_INSERT, 15, 5, 2, 0, alids_pkg::STAT_DONE, 0);
    add_row(alids_pkg::FUNC_SEARCH,  0, 5, 1, 0, alids_pkg::STAT_DONE, 0);
    add_row(alids_pkg::FUNC_DELETE,  1, '0, 16, 0, alids_pkg::STAT_DONE, 0);
    add_row(alids_pkg::FUNC_DELETE,  1, '0, 1, 1, alids_pkg::STAT_BADPOS, 0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table
    foreach (dir_rows[j]) begin
      for (n = 0; n < dir_rows[j].rep; n++) begin
        r.func = dir_rows[j].func;
        r.position = dir_rows[j].position;
        r.value = dir_rows[j].value;
        drive_item(r, dir_rows[j].checked, dir_rows[j].want);
        maybe_pause();
      end
    end
    wait_drained();

    // Random phase with one long receiver hold, one full drain, and a quiet tail
    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i == 100) long_hold_req = 1'b1;
      if (i == 200) wait_drained();
      if (i == RAND_ITEMS - 60) idle_on = 1'b0;
      r = make_random_req();
      drive_item(r, 1'b0, none);
      maybe_pause();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0 && rsp_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
